// File: sv/clktp_pkg.sv
// Shared types and constants for the clock time text parser.
// Parser state record, field and verdict codes, character codes.
// No dependencies.
`default_nettype none

package clktp_pkg;

	typedef enum logic [1:0] {
		FIELD_HOUR   = 2'd0,
		FIELD_MINUTE = 2'd1,
		FIELD_SECOND = 2'd2,
		FIELD_SUFFIX = 2'd3
	} field_t;

	typedef enum logic [1:0] {
		VERDICT_VALID        = 2'd0,
		VERDICT_INTERMEDIATE = 2'd1,
		VERDICT_INVALID      = 2'd2
	} verdict_t;

	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_UP    = 8'h50;
	localparam logic [7:0] CH_LP    = 8'h70;
	localparam logic [7:0] CH_UM    = 8'h4D;
	localparam logic [7:0] CH_LM    = 8'h6D;

	localparam logic [4:0] HOUR_MAX   = 5'd23;
	localparam logic [5:0] MINSEC_MAX = 6'd59;
	localparam logic [4:0] HOUR_NOON  = 5'd12;
	localparam logic [4:0] HOUR_AM_MAX = 5'd11;

	typedef struct packed {
		field_t     fidx;
		logic [1:0] dcnt;
		logic [5:0] accum;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic       in_suffix;
		logic [1:0] slen;
		logic [1:0] pend;
		logic       first_m;
		logic       held;
		verdict_t   held_code;
	} clktp_state_t;

	localparam clktp_state_t STATE_RESET = '{
		fidx:      FIELD_HOUR,
		dcnt:      2'd0,
		accum:     6'd0,
		hour:      5'd0,
		minute:    6'd0,
		second:    6'd0,
		in_suffix: 1'b0,
		slen:      2'd0,
		pend:      2'd0,
		first_m:   1'b0,
		held:      1'b0,
		held_code: VERDICT_VALID
	};

endpackage

`default_nettype wire

// File: sv/clktp_step.sv
// One character step of the time parser: next state and verdict.
// Purely combinational. Depends on clktp_pkg.
`default_nettype none

module clktp_step (
	input  wire clktp_pkg::clktp_state_t cur,
	input  wire logic [7:0]              ch,
	output clktp_pkg::clktp_state_t      nxt,
	output clktp_pkg::verdict_t          code
);

	logic       blank;
	logic       digit;
	logic       colon;
	logic       is_a;
	logic       is_p;
	logic       is_m;
	logic [9:0] val;
	logic [9:0] lim;
	logic [2:0] n;

	assign blank = (ch == clktp_pkg::CH_SPACE) ||
		((ch >= clktp_pkg::CH_TAB) && (ch <= clktp_pkg::CH_CR));
	assign digit = (ch >= clktp_pkg::CH_ZERO) && (ch <= clktp_pkg::CH_NINE);
	assign colon = (ch == clktp_pkg::CH_COLON);
	assign is_a  = (ch == clktp_pkg::CH_LA) || (ch == clktp_pkg::CH_UA);
	assign is_p  = (ch == clktp_pkg::CH_LP) || (ch == clktp_pkg::CH_UP);
	assign is_m  = (ch == clktp_pkg::CH_LM) || (ch == clktp_pkg::CH_UM);

	// accum * 10 + digit
	assign val = {1'b0, cur.accum, 3'b000} + {3'b000, cur.accum, 1'b0} + {6'd0, ch[3:0]};
	assign lim = (cur.fidx == clktp_pkg::FIELD_HOUR) ? {5'd0, clktp_pkg::HOUR_MAX}
		: {4'd0, clktp_pkg::MINSEC_MAX};
	assign n = {1'b0, cur.slen} + {1'b0, cur.pend} + 3'd1;

	always_comb begin
		nxt = cur;
		if (!cur.held) begin
			priority if (cur.in_suffix) begin
				if (blank) begin
					if (cur.pend < 2'd2) begin
						nxt.pend = cur.pend + 2'd1;
					end
				end else begin
					if ((cur.slen == 2'd0) && (cur.pend == 2'd0)) begin
						nxt.first_m = is_m;
					end
					nxt.slen = (n > 3'd2) ? 2'd2 : n[1:0];
					nxt.pend = 2'd0;
				end
			end else if (blank) begin
				nxt = cur;
			end else if (digit) begin
				if ((cur.fidx == clktp_pkg::FIELD_SUFFIX) || (cur.dcnt > 2'd1)) begin
					nxt.held      = 1'b1;
					nxt.held_code = clktp_pkg::VERDICT_INVALID;
				end else if (val > lim) begin
					nxt.held      = 1'b1;
					nxt.held_code = clktp_pkg::VERDICT_INTERMEDIATE;
				end else begin
					nxt.accum = val[5:0];
					nxt.dcnt  = cur.dcnt + 2'd1;
					unique case (cur.fidx)
						clktp_pkg::FIELD_HOUR: begin
							nxt.hour   = val[4:0];
							nxt.minute = 6'd0;
							nxt.second = 6'd0;
						end
						clktp_pkg::FIELD_MINUTE: begin
							nxt.minute = val[5:0];
							nxt.second = 6'd0;
						end
						default: begin
							nxt.second = val[5:0];
						end
					endcase
				end
			end else if (colon) begin
				if ((cur.fidx == clktp_pkg::FIELD_SECOND) ||
				    (cur.fidx == clktp_pkg::FIELD_SUFFIX) || (cur.dcnt == 2'd0)) begin
					nxt.held      = 1'b1;
					nxt.held_code = clktp_pkg::VERDICT_INTERMEDIATE;
				end else begin
					nxt.accum = 6'd0;
					nxt.dcnt  = 2'd0;
					nxt.fidx  = (cur.fidx == clktp_pkg::FIELD_HOUR) ?
						clktp_pkg::FIELD_MINUTE : clktp_pkg::FIELD_SECOND;
				end
			end else if (is_a || is_p) begin
				if ((cur.fidx == clktp_pkg::FIELD_HOUR) && (cur.dcnt == 2'd0)) begin
					nxt.held      = 1'b1;
					nxt.held_code = clktp_pkg::VERDICT_INTERMEDIATE;
				end else begin
					nxt.accum     = 6'd0;
					nxt.dcnt      = 2'd0;
					nxt.fidx      = clktp_pkg::FIELD_SUFFIX;
					nxt.in_suffix = 1'b1;
					if (cur.hour == clktp_pkg::HOUR_NOON) begin
						if (is_a) begin
							nxt.hour = 5'd0;
						end
					end else if (cur.hour > clktp_pkg::HOUR_AM_MAX) begin
						nxt.in_suffix = 1'b0;
						nxt.held      = 1'b1;
						nxt.held_code = clktp_pkg::VERDICT_INTERMEDIATE;
					end else if (is_p) begin
						nxt.hour = cur.hour + clktp_pkg::HOUR_NOON;
					end
				end
			end else begin
				nxt.held      = 1'b1;
				nxt.held_code = clktp_pkg::VERDICT_INVALID;
			end
		end
	end

	always_comb begin
		priority if (nxt.held) begin
			code = nxt.held_code;
		end else if (!nxt.in_suffix || (nxt.slen == 2'd0)) begin
			code = clktp_pkg::VERDICT_VALID;
		end else if (nxt.slen == 2'd1) begin
			code = nxt.first_m ? clktp_pkg::VERDICT_VALID : clktp_pkg::VERDICT_INVALID;
		end else begin
			code = clktp_pkg::VERDICT_INTERMEDIATE;
		end
	end

endmodule

`default_nettype wire

// File: sv/clock_time_text_parser_core.sv
// Clock time text parser, one character beat per cycle.
// A last beat is registered at the input; its result is then registered with out_valid.
// Throughput: one character per cycle; only a last beat waits while a result is stalled.
// arst_n clears the parser state and all valid flags; the state also
// returns to reset after each last beat. Depends on clktp_pkg, clktp_step.
`default_nettype none

module clock_time_text_parser_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] ch,
	input  wire        last,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [1:0] verdict,
	output logic [4:0] hour,
	output logic [5:0] minute,
	output logic [5:0] second,
	output logic [10:0] minutes_of_day
);

	logic                    valid_s1;
	logic [7:0]              ch_s1;
	logic                    last_s1;
	clktp_pkg::clktp_state_t state_q;
	clktp_pkg::clktp_state_t state_nxt;
	clktp_pkg::verdict_t     code;
	logic                    advance;
	logic                    fire;
	logic                    out_valid_q;
	logic [10:0]             mod_nxt;

	clktp_step u_step (
		.cur  (state_q),
		.ch   (ch_s1),
		.nxt  (state_nxt),
		.code (code)
	);

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && (!last_s1 || advance);
	assign in_stall = valid_s1 && last_s1 && !advance;

	// hour * 60 + minute
	assign mod_nxt = ({6'd0, state_nxt.hour} << 6) - ({6'd0, state_nxt.hour} << 2)
		+ {5'd0, state_nxt.minute};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clktp_pkg::STATE_RESET;
		end else if (fire) begin
			state_q <= last_s1 ? clktp_pkg::STATE_RESET : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			verdict        <= code;
			hour           <= state_nxt.hour;
			minute         <= state_nxt.minute;
			second         <= state_nxt.second;
			minutes_of_day <= mod_nxt;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: sv/clktp_checker.sv
// Port-level checks for the clock time text parser core, and its bind.
// Depends on clock_time_text_parser_core.
`default_nettype none

module clktp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [1:0]  verdict,
	input wire [4:0]  hour,
	input wire [5:0]  minute,
	input wire [5:0]  second,
	input wire [10:0] minutes_of_day
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(verdict) && $stable(minutes_of_day))
		else $error("result payload moved while stalled");

	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict != 2'd3) && (hour <= 5'd23) && (minute <= 6'd59) &&
			(second <= 6'd59) &&
			(minutes_of_day == ({6'd0, hour} * 11'd60 + {5'd0, minute})))
		else $error("result fields inconsistent");

endmodule

bind clock_time_text_parser_core clktp_checker u_clktp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.verdict        (verdict),
	.hour           (hour),
	.minute         (minute),
	.second         (second),
	.minutes_of_day (minutes_of_day)
);

`default_nettype wire
